// ===== rtl/core/ptc_pkg.sv =====
// shared types, constants and helpers for the pressure/temperature compensation core
// no dependencies; imported by every module in rtl/core
package ptc_pkg;

  localparam int unsigned DataW  = 64;
  localparam int unsigned HalfW  = DataW / 2;
  localparam int unsigned RawW   = 20;
  localparam int unsigned TempW  = 16;
  localparam int unsigned PressW = 32;
  localparam int unsigned FineW  = 32;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned MulLat = 2;
  localparam int unsigned DivLat = DataW + 2;

  localparam logic [33:0]      FineOffset = 34'd128000;
  localparam logic [RawW:0]    PressBase  = 21'd1048576;
  localparam logic [DataW-1:0] PressScale = 64'd3125;
  localparam logic [DataW-1:0] PressBias  = 64'h0000_8000_0000_0000;

  typedef enum logic [1:0] {
    CfgTemp   = 2'd0,
    CfgPressA = 2'd1,
    CfgPressB = 2'd2,
    CfgPressC = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [CoefW-1:0] t3;
    logic signed [CoefW-1:0] t2;
    logic [CoefW-1:0]        t1;
  } cal_temp_t;

  function automatic logic [DataW-1:0] sx16(input logic [CoefW-1:0] v);
    return {{(DataW-CoefW){v[CoefW-1]}}, v};
  endfunction

  function automatic logic [DataW-1:0] asr64(input logic [DataW-1:0] x, input int unsigned s);
    return $unsigned($signed(x) >>> s);
  endfunction

endpackage

// ===== rtl/core/ptc_mul64.sv =====
// two-stage pipelined multiplier, low 64 bits of a*b per lane, split into 32x32 partials
// depends on ptc_pkg
module ptc_mul64 import ptc_pkg::*; #(
  parameter int unsigned Lanes = 1,
  parameter int unsigned SbW   = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        vld_i,
  input  logic [Lanes-1:0][DataW-1:0] a_i,
  input  logic [Lanes-1:0][DataW-1:0] b_i,
  input  logic [SbW-1:0]              sb_i,
  output logic                        vld_o,
  output logic [Lanes-1:0][DataW-1:0] p_o,
  output logic [SbW-1:0]              sb_o
);

  logic [Lanes-1:0][DataW-1:0] lo_d, lo_q;
  logic [Lanes-1:0][HalfW-1:0] m1_d, m1_q, m2_d, m2_q;
  logic [Lanes-1:0][DataW-1:0] p_d, p_q;
  logic [SbW-1:0]              sb1_q, sb2_q;
  logic                        vld1_q, vld2_q;

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      lo_d[i] = {{HalfW{1'b0}}, a_i[i][HalfW-1:0]} * {{HalfW{1'b0}}, b_i[i][HalfW-1:0]};
      m1_d[i] = a_i[i][DataW-1:HalfW] * b_i[i][HalfW-1:0];
      m2_d[i] = a_i[i][HalfW-1:0] * b_i[i][DataW-1:HalfW];
    end
  end

  always_comb begin
    for (int i = 0; i < Lanes; i++) begin
      p_d[i] = lo_q[i] + {m1_q[i] + m2_q[i], {HalfW{1'b0}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    sb1_q <= sb_i;
    p_q   <= p_d;
    sb2_q <= sb1_q;
  end

  assign vld_o = vld2_q;
  assign p_o   = p_q;
  assign sb_o  = sb2_q;

endmodule

// ===== rtl/core/ptc_div64.sv =====
// pipelined signed 64-bit divider, one restoring step per stage, truncating quotient
// depends on ptc_pkg
module ptc_div64 import ptc_pkg::*; #(
  parameter int unsigned SbW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [DataW-1:0] num_i,
  input  logic [DataW-1:0] den_i,
  input  logic [SbW-1:0]   sb_i,
  output logic             vld_o,
  output logic [DataW-1:0] quo_o,
  output logic [SbW-1:0]   sb_o
);

  logic [DataW:0]              vld_q;
  logic [DataW-1:0][DataW-1:0] rem_q, dvs_q;
  logic [DataW:0][DataW-1:0]   dvd_q;
  logic [DataW:0]              neg_q;
  logic [DataW:0][SbW-1:0]     sb_q;
  logic [DataW:1][DataW-1:0]   dvd_d;
  logic [DataW-1:1][DataW-1:0] rem_d;
  logic                        out_vld_q;
  logic [DataW-1:0]            quo_q;
  logic [SbW-1:0]              out_sb_q;

  for (genvar k = 1; k <= DataW; k++) begin : g_step
    logic [DataW:0] trial;
    logic           ge;
    assign trial    = {rem_q[k-1], dvd_q[k-1][DataW-1]};
    assign ge       = trial >= {1'b0, dvs_q[k-1]};
    assign dvd_d[k] = {dvd_q[k-1][DataW-2:0], ge};

    // the last step only yields a quotient bit
    if (k < DataW) begin : g_rem
      logic [DataW-1:0] diff;
      assign diff     = trial[DataW-1:0] - dvs_q[k-1];
      assign rem_d[k] = ge ? diff : trial[DataW-1:0];
    end
  end

  // stage 0: magnitudes and result sign, then one step per stage
  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    dvd_q[0] <= num_i[DataW-1] ? (~num_i + 1'b1) : num_i;
    dvs_q[0] <= den_i[DataW-1] ? (~den_i + 1'b1) : den_i;
    neg_q[0] <= num_i[DataW-1] ^ den_i[DataW-1];
    sb_q[0]  <= sb_i;
    for (int k = 1; k < DataW; k++) begin
      rem_q[k] <= rem_d[k];
      dvs_q[k] <= dvs_q[k-1];
    end
    for (int k = 1; k <= DataW; k++) begin
      dvd_q[k] <= dvd_d[k];
      neg_q[k] <= neg_q[k-1];
      sb_q[k]  <= sb_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      vld_q     <= {vld_q[DataW-1:0], vld_i};
      out_vld_q <= vld_q[DataW];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q    <= neg_q[DataW] ? (~dvd_q[DataW] + 1'b1) : dvd_q[DataW];
    out_sb_q <= sb_q[DataW];
  end

  assign vld_o = out_vld_q;
  assign quo_o = quo_q;
  assign sb_o  = out_sb_q;

endmodule

// ===== rtl/core/ptc_temp.sv =====
// temperature path: five register stages from raw reading to fine and centidegree value
// depends on ptc_pkg
module ptc_temp import ptc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    vld_i,
  input  logic [RawW-1:0]         raw_t_i,
  input  logic [RawW-1:0]         raw_p_i,
  input  cal_temp_t               cal_i,
  output logic                    vld_o,
  output logic [FineW-1:0]        tfine_o,
  output logic signed [TempW-1:0] temp_o,
  output logic [RawW-1:0]         raw_p_o
);

  logic [4:0] vld_q;

  // stage 1
  logic [17:0]     a_d, a_q;
  logic [16:0]     dl_d, dl_q;
  logic [RawW-1:0] rp1_q, rp2_q, rp3_q, rp4_q, rp5_q;

  assign a_d  = {1'b0, raw_t_i[RawW-1:3]} - {1'b0, cal_i.t1, 1'b0};
  assign dl_d = {1'b0, raw_t_i[RawW-1:4]} - {1'b0, cal_i.t1};

  // stage 2
  logic signed [33:0] m1_full, dd_full;
  logic [FineW-1:0]   m1_q, dd_q;

  assign m1_full = $signed(a_q) * cal_i.t2;
  assign dd_full = $signed(dl_q) * $signed(dl_q);

  // stage 3
  logic signed [FineW-1:0] e_s;
  logic [FineW-1:0]        m3_d, m3_q, v1_q;

  assign e_s  = $signed(dd_q) >>> 12;
  assign m3_d = e_s * FineW'(cal_i.t3);

  // stage 4
  logic [FineW-1:0] tf4_q, tf5_q;

  // stage 5: (tf*5 + 128) >>> 8, saturated
  logic [FineW-1:0]        x5;
  logic signed [FineW-1:0] tc;
  logic signed [TempW-1:0] temp_d, temp_q;

  assign x5 = tf4_q + {tf4_q[FineW-3:0], 2'b00} + FineW'(128);
  assign tc = $signed(x5) >>> 8;

  always_comb begin
    if (tc < -32'sd32768) begin
      temp_d = -16'sd32768;
    end else if (tc > 32'sd32767) begin
      temp_d = 16'sd32767;
    end else begin
      temp_d = tc[TempW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[3:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    dl_q   <= dl_d;
    rp1_q  <= raw_p_i;
    m1_q   <= m1_full[FineW-1:0];
    dd_q   <= dd_full[FineW-1:0];
    rp2_q  <= rp1_q;
    v1_q   <= $unsigned($signed(m1_q) >>> 11);
    m3_q   <= m3_d;
    rp3_q  <= rp2_q;
    tf4_q  <= v1_q + $unsigned($signed(m3_q) >>> 14);
    rp4_q  <= rp3_q;
    tf5_q  <= tf4_q;
    temp_q <= temp_d;
    rp5_q  <= rp4_q;
  end

  assign vld_o   = vld_q[4];
  assign tfine_o = tf5_q;
  assign temp_o  = temp_q;
  assign raw_p_o = rp5_q;

endmodule

// ===== rtl/core/pressure_temp_compensation_core.sv =====
// top level: calibration registers, pressure path stages, multiplier and divider units
// depends on ptc_pkg, ptc_temp, ptc_mul64, ptc_div64
//
// channel   signals                                               direction
// config    cfg_we_i, cfg_idx_i, cfg_wdata_i                      in
// input     start_i, busy_o, raw_pressure_i, raw_temperature_i    in
// result    res_valid_o, temp_centideg_o, press_q24_8_o, div_error_o out
//
// one item per cycle; busy_o stays low, so a transfer happens whenever start_i is high
// a result is on the ports for one cycle under res_valid_o
// the path holds the 66-stage division pipeline and eight multiplier stages besides the other stages
// reset clears the pipeline valid bits and the calibration registers
// nothing stalls: every stage advances each cycle and the receiver takes every result
module pressure_temp_compensation_core import ptc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [RawW-1:0]          raw_pressure_i,
  input  logic [RawW-1:0]          raw_temperature_i,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [DataW-1:0]         cfg_wdata_i,
  output logic                     res_valid_o,
  output logic signed [TempW-1:0]  temp_centideg_o,
  output logic [PressW-1:0]        press_q24_8_o,
  output logic                     div_error_o
);

  // calibration registers
  cal_temp_t        cal_t_q;
  logic [DataW-1:0] cal_a_q, cal_b_q;
  logic [CoefW-1:0] cal_c_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_t_q <= '0;
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgTemp:   cal_t_q <= cal_temp_t'(cfg_wdata_i[47:0]);
        CfgPressA: cal_a_q <= cfg_wdata_i;
        CfgPressB: cal_b_q <= cfg_wdata_i;
        CfgPressC: cal_c_q <= cfg_wdata_i[CoefW-1:0];
        default:   cal_c_q <= cal_c_q;
      endcase
    end
  end

  logic [CoefW-1:0] p1, p2, p3, p4, p5, p6, p7, p8;
  assign p1 = cal_a_q[15:0];
  assign p2 = cal_a_q[31:16];
  assign p3 = cal_a_q[47:32];
  assign p4 = cal_a_q[63:48];
  assign p5 = cal_b_q[15:0];
  assign p6 = cal_b_q[31:16];
  assign p7 = cal_b_q[47:32];
  assign p8 = cal_b_q[63:48];

  assign busy_o = 1'b0;

  // input register
  logic            in_vld_q;
  logic [RawW-1:0] in_rp_q, in_rt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    in_rp_q <= raw_pressure_i;
    in_rt_q <= raw_temperature_i;
  end

  // temperature path
  logic                    t_vld;
  logic [FineW-1:0]        t_fine;
  logic signed [TempW-1:0] t_temp;
  logic [RawW-1:0]         t_rp;

  ptc_temp u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .vld_i   (in_vld_q),
    .raw_t_i (in_rt_q),
    .raw_p_i (in_rp_q),
    .cal_i   (cal_t_q),
    .vld_o   (t_vld),
    .tfine_o (t_fine),
    .temp_o  (t_temp),
    .raw_p_o (t_rp)
  );

  // pressure stage 1: offset fine temperature
  logic                    s1_vld_q;
  logic [33:0]             s1_w_q;
  logic [TempW-1:0]        s1_temp_q;
  logic [RawW-1:0]         s1_rp_q;

  // pressure stage 2: square and linear terms
  logic signed [67:0] ww_full;
  logic signed [49:0] wp5_full, wp2_full;
  logic               s2_vld_q;
  logic [DataW-1:0]   s2_ww_q;
  logic [49:0]        s2_wp5_q, s2_wp2_q;
  logic [TempW-1:0]   s2_temp_q;
  logic [RawW-1:0]    s2_rp_q;

  assign ww_full  = $signed(s1_w_q) * $signed(s1_w_q);
  assign wp5_full = $signed(s1_w_q) * $signed(p5);
  assign wp2_full = $signed(s1_w_q) * $signed(p2);

  // quadratic terms: lane 0 times p3, lane 1 times p6
  localparam int unsigned SbA = 50 + 50 + TempW + RawW;
  logic                   ma_vld;
  logic [1:0][DataW-1:0]  ma_p;
  logic [SbA-1:0]         ma_sb;
  logic [49:0]            ma_wp5, ma_wp2;
  logic [TempW-1:0]       ma_temp;
  logic [RawW-1:0]        ma_rp;

  ptc_mul64 #(.Lanes(2), .SbW(SbA)) u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s2_vld_q),
    .a_i    ({s2_ww_q, s2_ww_q}),
    .b_i    ({sx16(p6), sx16(p3)}),
    .sb_i   ({s2_wp5_q, s2_wp2_q, s2_temp_q, s2_rp_q}),
    .vld_o  (ma_vld),
    .p_o    (ma_p),
    .sb_o   (ma_sb)
  );

  assign {ma_wp5, ma_wp2, ma_temp, ma_rp} = ma_sb;

  // pressure stage 5: w2 and the divisor operand
  logic [DataW-1:0] w2_d, v_d, s_d;
  logic             s5_vld_q;
  logic [DataW-1:0] s5_w2_q, s5_s_q;
  logic [TempW-1:0] s5_temp_q;
  logic [RawW-1:0]  s5_rp_q;

  assign w2_d = ma_p[1] + ({{14{ma_wp5[49]}}, ma_wp5} << 17) + (sx16(p4) << 35);
  assign v_d  = asr64(ma_p[0], 8) + ({{14{ma_wp2[49]}}, ma_wp2} << 12);
  assign s_d  = PressBias + v_d;

  // pressure stage 6: dividend before scaling
  logic [RawW:0]    pp;
  logic             s6_vld_q;
  logic [DataW-1:0] s6_num_q, s6_s_q;
  logic [TempW-1:0] s6_temp_q;

  assign pp = PressBase - {1'b0, s5_rp_q};

  // lane 0: divisor times p1, lane 1: dividend times scale
  logic                  mb_vld;
  logic [1:0][DataW-1:0] mb_p;
  logic [TempW-1:0]      mb_temp;

  ptc_mul64 #(.Lanes(2), .SbW(TempW)) u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s6_vld_q),
    .a_i    ({s6_num_q, s6_s_q}),
    .b_i    ({PressScale, {(DataW-CoefW){1'b0}}, p1}),
    .sb_i   (s6_temp_q),
    .vld_o  (mb_vld),
    .p_o    (mb_p),
    .sb_o   (mb_temp)
  );

  // pressure stage 9: divisor and zero check
  logic [DataW-1:0] w1_d;
  logic             s9_vld_q;
  logic [DataW-1:0] s9_num_q, s9_den_q;
  logic [TempW-1:0] s9_temp_q;
  logic             s9_err_q;

  assign w1_d = asr64(mb_p[0], 33);

  logic             dv_vld;
  logic [DataW-1:0] dv_quo;
  logic [TempW:0]   dv_sb;

  ptc_div64 #(.SbW(TempW + 1)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (s9_vld_q),
    .num_i  (s9_num_q),
    .den_i  (s9_den_q),
    .sb_i   ({s9_temp_q, s9_err_q}),
    .vld_o  (dv_vld),
    .quo_o  (dv_quo),
    .sb_o   (dv_sb)
  );

  // lane 0: q*q, lane 1: p*p8
  localparam int unsigned SbC = DataW + TempW + 1;
  logic [DataW-1:0]      dv_q;
  logic                  mc_vld;
  logic [1:0][DataW-1:0] mc_p;
  logic [SbC-1:0]        mc_sb;
  logic [DataW-1:0]      mc_pv;
  logic [TempW:0]        mc_te;

  assign dv_q = asr64(dv_quo, 13);

  ptc_mul64 #(.Lanes(2), .SbW(SbC)) u_mul_c (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (dv_vld),
    .a_i    ({dv_quo, dv_q}),
    .b_i    ({sx16(p8), dv_q}),
    .sb_i   ({dv_quo, dv_sb}),
    .vld_o  (mc_vld),
    .p_o    (mc_p),
    .sb_o   (mc_sb)
  );

  assign {mc_pv, mc_te} = mc_sb;

  // q*q times p9
  localparam int unsigned SbD = 2 * DataW + TempW + 1;
  logic                  md_vld;
  logic [0:0][DataW-1:0] md_p;
  logic [SbD-1:0]        md_sb;
  logic [DataW-1:0]      md_x2, md_pv;
  logic [TempW-1:0]      md_temp;
  logic                  md_err;

  ptc_mul64 #(.Lanes(1), .SbW(SbD)) u_mul_d (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (mc_vld),
    .a_i    (mc_p[0]),
    .b_i    (sx16(cal_c_q)),
    .sb_i   ({asr64(mc_p[1], 19), mc_pv, mc_te}),
    .vld_o  (md_vld),
    .p_o    (md_p),
    .sb_o   (md_sb)
  );

  assign {md_x2, md_pv, md_temp, md_err} = md_sb;

  // final sum, then shift, offset and saturation
  logic             q5_vld_q;
  logic [DataW-1:0] q5_sum_q;
  logic [TempW-1:0] q5_temp_q;
  logic             q5_err_q;

  logic [DataW-1:0]  r_d;
  logic [PressW-1:0] press_d;

  assign r_d = asr64(q5_sum_q, 8) + (sx16(p7) << 4);

  always_comb begin
    if (q5_err_q || r_d[DataW-1]) begin
      press_d = '0;
    end else if (r_d[DataW-1:PressW] != '0) begin
      press_d = '1;
    end else begin
      press_d = r_d[PressW-1:0];
    end
  end

  logic                    out_vld_q;
  logic signed [TempW-1:0] out_temp_q;
  logic [PressW-1:0]       out_press_q;
  logic                    out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      s6_vld_q  <= 1'b0;
      s9_vld_q  <= 1'b0;
      q5_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= t_vld;
      s2_vld_q  <= s1_vld_q;
      s5_vld_q  <= ma_vld;
      s6_vld_q  <= s5_vld_q;
      s9_vld_q  <= mb_vld;
      q5_vld_q  <= md_vld;
      out_vld_q <= q5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_w_q      <= {{2{t_fine[FineW-1]}}, t_fine} - FineOffset;
    s1_temp_q   <= t_temp;
    s1_rp_q     <= t_rp;
    s2_ww_q     <= ww_full[DataW-1:0];
    s2_wp5_q    <= wp5_full;
    s2_wp2_q    <= wp2_full;
    s2_temp_q   <= s1_temp_q;
    s2_rp_q     <= s1_rp_q;
    s5_w2_q     <= w2_d;
    s5_s_q      <= s_d;
    s5_temp_q   <= ma_temp;
    s5_rp_q     <= ma_rp;
    s6_num_q    <= ({{(DataW-RawW-1){1'b0}}, pp} << 31) - s5_w2_q;
    s6_s_q      <= s5_s_q;
    s6_temp_q   <= s5_temp_q;
    s9_num_q    <= mb_p[1];
    s9_den_q    <= w1_d;
    s9_err_q    <= (w1_d == '0);
    s9_temp_q   <= mb_temp;
    q5_sum_q    <= md_pv + asr64(md_p[0], 25) + md_x2;
    q5_temp_q   <= md_temp;
    q5_err_q    <= md_err;
    out_temp_q  <= q5_temp_q;
    out_press_q <= press_d;
    out_err_q   <= q5_err_q;
  end

  assign res_valid_o     = out_vld_q;
  assign temp_centideg_o = out_temp_q;
  assign press_q24_8_o   = out_press_q;
  assign div_error_o     = out_err_q;

  localparam int unsigned Lat = 1 + 5 + 2 + MulLat + 2 + MulLat + 1 + DivLat + 2 * MulLat + 2;

`ifndef SYNTHESIS
  // every result traces back to a transfer exactly one pipeline depth earlier
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(start_i && !busy_o, Lat))
    else $error("result without matching transfer");

  // a zero divisor must force the pressure to zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && div_error_o) |-> (press_q24_8_o == '0))
    else $error("pressure nonzero on divide error");

  // a zero divisor flagged at the divider input reaches the output with the item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s9_vld_q && s9_den_q == '0) |-> ##(Lat - 15) (res_valid_o && div_error_o))
    else $error("divide error lost in pipeline");
`endif

endmodule
